// File: hw/rtl/s2c_pkg.sv
`default_nettype none

package s2c_pkg;

    // register map, indexed by paddr[2]
    localparam logic REG_DEGREE_MODE   = 1'b0;
    localparam logic REG_SPHERE_RADIUS = 1'b1;

    localparam logic [30:0] SPHERE_RADIUS_RESET = 31'd444774400;

    // 360 degrees in Q9.22
    localparam logic signed [33:0] DEG_TURN = 34'sd1509949440;
    // floor(2^37 / 45), quotient estimate for m / 45
    localparam logic [31:0] DEG_RECIP = 32'd3054198966;
    localparam logic [31:0] DEG_DIV = 32'd45;
    // ceil(2^19 / 45) * 128, gives floor(r * 128 / 45) for r < 45
    localparam logic [20:0] FRAC_RECIP = 21'd1491328;
    // low part of (16/pi) * 2^32, the high part is 5
    localparam logic [28:0] RAD_C_LO = 29'd399252338;

    localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;

    localparam logic signed [33:0] OUT_MAX = 34'sh1FFFFFFFF;
    localparam logic signed [33:0] OUT_MIN = 34'sh200000000;

    typedef logic [1:0] quadrant_t;

    function automatic logic signed [31:0] atan_turn(input int unsigned idx);
        logic signed [31:0] v;
        begin
            case (idx)
                0:  v = 32'sh20000000;
                1:  v = 32'sh12E4051E;
                2:  v = 32'sh09FB385B;
                3:  v = 32'sh051111D4;
                4:  v = 32'sh028B0D43;
                5:  v = 32'sh0145D7E1;
                6:  v = 32'sh00A2F61E;
                7:  v = 32'sh00517C55;
                8:  v = 32'sh0028BE53;
                9:  v = 32'sh00145F2F;
                10: v = 32'sh000A2F98;
                11: v = 32'sh000517CC;
                12: v = 32'sh00028BE6;
                13: v = 32'sh000145F3;
                14: v = 32'sh0000A2FA;
                15: v = 32'sh0000517D;
                16: v = 32'sh000028BE;
                17: v = 32'sh0000145F;
                18: v = 32'sh00000A30;
                19: v = 32'sh00000518;
                20: v = 32'sh0000028C;
                21: v = 32'sh00000146;
                22: v = 32'sh000000A3;
                23: v = 32'sh00000051;
                24: v = 32'sh00000029;
                25: v = 32'sh00000014;
                26: v = 32'sh0000000A;
                27: v = 32'sh00000005;
                28: v = 32'sh00000003;
                29: v = 32'sh00000001;
                30: v = 32'sh00000001;
                default: v = 32'sh00000000;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/s2c_phase.sv
`default_nettype none

// angle to 32-bit phase (2^32 per turn), four register stages
module s2c_phase
(
    input  wire logic               clk,
    input  wire logic signed [31:0] angle,
    input  wire logic               degree_mode,
    output logic [31:0]             phase
);

    logic signed [33:0] a_ext;
    logic signed [33:0] wrap_next;
    logic [30:0]        m1_reg;
    logic signed [31:0] a1_reg;

    logic [62:0]        pdeg_reg;
    logic signed [61:0] prad_reg;
    logic [30:0]        m2_reg;
    logic signed [31:0] a2_reg;

    logic [25:0]        q_est;
    logic [31:0]        q_mul;
    logic [31:0]        r_wide;
    logic signed [31:0] a5;
    logic [31:0]        rad_next;
    logic [24:0]        q3_reg;
    logic [6:0]         r3_reg;
    logic [31:0]        rad3_reg;

    logic [24:0]        q_fix;
    logic [5:0]         r_fix;
    logic [26:0]        frac_prod;
    logic [31:0]        phase_next;
    logic [31:0]        phase_reg;

    // floor modulo of one turn, at most two corrections for a 32-bit angle
    always_comb
    begin
        a_ext = 34'(angle);
        if (a_ext < -s2c_pkg::DEG_TURN)
            wrap_next = a_ext + (s2c_pkg::DEG_TURN <<< 1);
        else if (a_ext < 34'sd0)
            wrap_next = a_ext + s2c_pkg::DEG_TURN;
        else if (a_ext >= s2c_pkg::DEG_TURN)
            wrap_next = a_ext - s2c_pkg::DEG_TURN;
        else
            wrap_next = a_ext;
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= wrap_next[30:0];
        a1_reg <= angle;
    end

    always_ff @(posedge clk)
    begin
        pdeg_reg <= 63'(m1_reg) * 63'(s2c_pkg::DEG_RECIP);
        prad_reg <= 62'(a1_reg) * $signed(62'(s2c_pkg::RAD_C_LO));
        m2_reg   <= m1_reg;
        a2_reg   <= a1_reg;
    end

    // quotient estimate is exact or one low
    always_comb
    begin
        q_est    = pdeg_reg[62:37];
        q_mul    = 32'(q_est) * s2c_pkg::DEG_DIV;
        r_wide   = 32'(m2_reg) - q_mul;
        a5       = a2_reg + (a2_reg <<< 2);
        rad_next = {{2{prad_reg[61]}}, prad_reg[61:32]} + 32'(a5);
    end

    always_ff @(posedge clk)
    begin
        q3_reg   <= q_est[24:0];
        r3_reg   <= r_wide[6:0];
        rad3_reg <= rad_next;
    end

    always_comb
    begin
        if (r3_reg >= 7'(s2c_pkg::DEG_DIV))
        begin
            q_fix = q3_reg + 25'd1;
            r_fix = 6'(r3_reg - 7'(s2c_pkg::DEG_DIV));
        end
        else
        begin
            q_fix = q3_reg;
            r_fix = r3_reg[5:0];
        end
        frac_prod  = 27'(r_fix) * 27'(s2c_pkg::FRAC_RECIP);
        phase_next = degree_mode ? {q_fix, frac_prod[25:19]} : rad3_reg;
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

// File: hw/rtl/s2c_cordic.sv
`default_nettype none

// pipelined rotation cordic, one step per stage, quadrant fold at the end
module s2c_cordic
#(
    parameter int STEPS = 24
)
(
    input  wire logic        clk,
    input  wire logic [31:0] phase,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);

    logic signed [31:0]   x_in [0:STEPS-1];
    logic signed [31:0]   y_in [0:STEPS-1];
    logic signed [31:0]   z_in [0:STEPS-1];
    s2c_pkg::quadrant_t   q_in [0:STEPS-1];

    logic signed [31:0]   x_reg [1:STEPS];
    logic signed [31:0]   y_reg [1:STEPS];
    logic signed [31:0]   z_reg [1:STEPS];
    s2c_pkg::quadrant_t   q_reg [1:STEPS];

    logic signed [31:0]   cos_next;
    logic signed [31:0]   sin_next;
    logic signed [31:0]   cos_reg;
    logic signed [31:0]   sin_reg;

    assign x_in[0] = s2c_pkg::CORDIC_GAIN_INV;
    assign y_in[0] = 32'sd0;
    assign z_in[0] = $signed({2'b00, phase[29:0]});
    assign q_in[0] = phase[31:30];

    genvar i;
    generate
        for (i = 1; i < STEPS; i++)
        begin : g_link
            assign x_in[i] = x_reg[i];
            assign y_in[i] = y_reg[i];
            assign z_in[i] = z_reg[i];
            assign q_in[i] = q_reg[i];
        end

        for (i = 0; i < STEPS; i++)
        begin : g_step
            logic signed [31:0] dx;
            logic signed [31:0] dy;
            assign dx = x_in[i] >>> i;
            assign dy = y_in[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (z_in[i] >= 32'sd0)
                begin
                    x_reg[i+1] <= x_in[i] - dy;
                    y_reg[i+1] <= y_in[i] + dx;
                    z_reg[i+1] <= z_in[i] - s2c_pkg::atan_turn(i);
                end
                else
                begin
                    x_reg[i+1] <= x_in[i] + dy;
                    y_reg[i+1] <= y_in[i] - dx;
                    z_reg[i+1] <= z_in[i] + s2c_pkg::atan_turn(i);
                end
                q_reg[i+1] <= q_in[i];
            end
        end
    endgenerate

    always_comb
    begin
        case (q_reg[STEPS])
            2'd0:
            begin
                cos_next = x_reg[STEPS];
                sin_next = y_reg[STEPS];
            end
            2'd1:
            begin
                cos_next = -y_reg[STEPS];
                sin_next = x_reg[STEPS];
            end
            2'd2:
            begin
                cos_next = -x_reg[STEPS];
                sin_next = -y_reg[STEPS];
            end
            default:
            begin
                cos_next = y_reg[STEPS];
                sin_next = -x_reg[STEPS];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

`default_nettype wire

// File: hw/rtl/spherical_to_cartesian.sv
// done follows each accepted start down the valid pipeline, in step with its result
// throughput: one point per cycle, busy stays low
// depth is set by the cordic, one rotation step per pipeline stage
// the receiver cannot stall, each result shows for one cycle with done
// rst_n clears the valid pipeline and loads degree_mode = 1 and the default radius
`default_nettype none

module spherical_to_cartesian
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] longitude,
    input  wire logic signed [31:0] latitude,
    input  wire logic signed [31:0] altitude,
    output logic                    done,
    output logic signed [33:0]      x_coord,
    output logic signed [33:0]      y_coord,
    output logic signed [33:0]      z_coord
);

    localparam int TRIG_LAT = CORDIC_STEPS + 5;
    localparam int LAT      = TRIG_LAT + 3;

    logic        degree_mode_reg;
    logic [30:0] sphere_radius_reg;
    logic        cfg_wr;

    logic               accept;
    logic               vld_reg [0:LAT-1];
    logic signed [32:0] d_next;
    logic signed [32:0] d_reg [0:TRIG_LAT-1];

    logic [31:0]        lon_phase;
    logic [31:0]        lat_phase;
    logic signed [31:0] cos_lon;
    logic signed [31:0] sin_lon;
    logic signed [31:0] cos_lat;
    logic signed [31:0] sin_lat;

    logic signed [64:0] p_t;
    logic signed [64:0] p_z;
    logic signed [34:0] t_reg;
    logic signed [34:0] z1_reg;
    logic signed [31:0] co_reg;
    logic signed [31:0] so_reg;

    logic signed [66:0] p_x;
    logic signed [66:0] p_y;
    logic signed [36:0] x2_reg;
    logic signed [36:0] y2_reg;
    logic signed [34:0] z2_reg;

    logic signed [33:0] x_out_reg;
    logic signed [33:0] y_out_reg;
    logic signed [33:0] z_out_reg;

    function automatic logic signed [33:0] sat34(input logic signed [36:0] v);
        begin
            if (v > 37'(s2c_pkg::OUT_MAX))
                return s2c_pkg::OUT_MAX;
            else if (v < 37'(s2c_pkg::OUT_MIN))
                return s2c_pkg::OUT_MIN;
            else
                return v[33:0];
        end
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_mode_reg   <= 1'b1;
            sphere_radius_reg <= s2c_pkg::SPHERE_RADIUS_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                s2c_pkg::REG_DEGREE_MODE:   degree_mode_reg <= pwdata[0];
                s2c_pkg::REG_SPHERE_RADIUS: sphere_radius_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            s2c_pkg::REG_DEGREE_MODE:   prdata = {31'd0, degree_mode_reg};
            s2c_pkg::REG_SPHERE_RADIUS: prdata = {1'b0, sphere_radius_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // request handshake
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // distance, delayed to meet the trig results
    assign d_next = 33'(altitude)
                  + (degree_mode_reg ? $signed({2'b00, sphere_radius_reg}) : 33'sd0);

    always_ff @(posedge clk)
    begin
        d_reg[0] <= d_next;
        for (int k = 1; k < TRIG_LAT; k++)
            d_reg[k] <= d_reg[k-1];
    end

    s2c_phase u_lon_phase
    (
        .clk         (clk),
        .angle       (longitude),
        .degree_mode (degree_mode_reg),
        .phase       (lon_phase)
    );

    s2c_phase u_lat_phase
    (
        .clk         (clk),
        .angle       (latitude),
        .degree_mode (degree_mode_reg),
        .phase       (lat_phase)
    );

    s2c_cordic #(.STEPS(CORDIC_STEPS)) u_lon_cordic
    (
        .clk     (clk),
        .phase   (lon_phase),
        .cos_val (cos_lon),
        .sin_val (sin_lon)
    );

    s2c_cordic #(.STEPS(CORDIC_STEPS)) u_lat_cordic
    (
        .clk     (clk),
        .phase   (lat_phase),
        .cos_val (cos_lat),
        .sin_val (sin_lat)
    );

    // round to nearest after each product
    assign p_t = 65'(d_reg[TRIG_LAT-1]) * 65'(cos_lat) + 65'sd536870912;
    assign p_z = 65'(d_reg[TRIG_LAT-1]) * 65'(sin_lat) + 65'sd536870912;

    always_ff @(posedge clk)
    begin
        t_reg  <= p_t[64:30];
        z1_reg <= p_z[64:30];
        co_reg <= cos_lon;
        so_reg <= sin_lon;
    end

    assign p_x = 67'(t_reg) * 67'(co_reg) + 67'sd536870912;
    assign p_y = 67'(t_reg) * 67'(so_reg) + 67'sd536870912;

    always_ff @(posedge clk)
    begin
        x2_reg <= p_x[66:30];
        y2_reg <= p_y[66:30];
        z2_reg <= z1_reg;
    end

    always_ff @(posedge clk)
    begin
        x_out_reg <= sat34(x2_reg);
        y_out_reg <= sat34(y2_reg);
        z_out_reg <= sat34(37'(z2_reg));
    end

    assign done    = vld_reg[LAT-1];
    assign x_coord = x_out_reg;
    assign y_coord = y_out_reg;
    assign z_coord = z_out_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("request lost in pipeline");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without request");

    a_no_saturation: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(x_coord == s2c_pkg::OUT_MIN || y_coord == s2c_pkg::OUT_MIN
                   || z_coord == s2c_pkg::OUT_MIN))
        else $error("result reached negative limit");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

typedef struct {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
} xyz_t;

class point_scoreboard;
    bit              deg_mode;
    bit [30:0]       radius;
    xyz_t            pending_q[$];
    int              mismatches;
    longint          atan_tab[32];

    function new();
        atan_tab = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
            64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
            64'h00000001, 64'h00000000};
        deg_mode = 1'b1;
        radius = s2c_pkg::SPHERE_RADIUS_RESET;
        mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] value);
        if (addr[2] == s2c_pkg::REG_DEGREE_MODE)
            deg_mode = value[0];
        else
            radius = value[30:0];
    endfunction

    function bit [31:0] angle_phase(logic signed [31:0] ang);
        longint     a;
        longint     m;
        bit [63:0]  ua;
        bit [63:0]  prod;
        a = longint'(ang);
        if (deg_mode)
        begin
            m = a % 64'sd1509949440;
            if (m < 0)
                m += 64'sd1509949440;
            ua = m;
            return 32'((ua << 32) / 64'd1509949440);
        end
        ua = a;
        prod = ua * 64'd21874088818;
        return prod[63:32];
    endfunction

    function void sin_cos(bit [31:0] ph, output longint c, output longint s);
        longint xr;
        longint yr;
        longint zr;
        longint dx;
        longint dy;
        xr = longint'(s2c_pkg::CORDIC_GAIN_INV);
        yr = 64'sd0;
        zr = longint'(ph[29:0]);
        for (int i = 0; i < 24; i++)
        begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (zr >= 0)
            begin
                xr -= dx;
                yr += dy;
                zr -= atan_tab[i];
            end
            else
            begin
                xr += dx;
                yr -= dy;
                zr += atan_tab[i];
            end
        end
        // rotate by the quadrant taken off the top of the phase
        case (ph[31:30])
            2'd0:
            begin
                c = xr;
                s = yr;
            end
            2'd1:
            begin
                c = -yr;
                s = xr;
            end
            2'd2:
            begin
                c = -xr;
                s = -yr;
            end
            default:
            begin
                c = yr;
                s = -xr;
            end
        endcase
    endfunction

    function longint mul_round(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function logic signed [33:0] clamp34(longint v);
        if (v > 64'sd8589934591)
            return s2c_pkg::OUT_MAX;
        if (v < -64'sd8589934592)
            return s2c_pkg::OUT_MIN;
        return v[33:0];
    endfunction

    function void note_request(logic signed [31:0] lon, logic signed [31:0] lat,
                               logic signed [31:0] alt);
        longint co;
        longint so;
        longint cl;
        longint sl;
        longint d;
        longint t;
        xyz_t   e;
        d = longint'(alt);
        if (deg_mode)
            d += longint'(radius);
        sin_cos(angle_phase(lon), co, so);
        sin_cos(angle_phase(lat), cl, sl);
        t = mul_round(d, cl);
        e.x = clamp34(mul_round(t, co));
        e.y = clamp34(mul_round(t, so));
        e.z = clamp34(mul_round(d, sl));
        pending_q.push_back(e);
    endfunction

    function void check_result(logic signed [33:0] x, logic signed [33:0] y,
                               logic signed [33:0] z);
        xyz_t e;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result x=%0d y=%0d z=%0d", x, y, z);
            return;
        end
        e = pending_q.pop_front();
        if (x !== e.x || y !== e.y || z !== e.z)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                         e.x, e.y, e.z, x, y, z);
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] altitude;
    logic               done;
    logic signed [33:0] x_coord;
    logic signed [33:0] y_coord;
    logic signed [33:0] z_coord;

    point_scoreboard    sb;
    int                 sent;

    localparam int       ITEMS = 650;
    localparam longint   DEG = 64'sd4194304;    // one degree in Q9.22

    spherical_to_cartesian DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .longitude(longitude), .latitude(latitude), .altitude(altitude),
        .done(done), .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // values read here are the ones the block sees at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
                sb.write_reg(paddr, pwdata);
            if (start && !busy)
                sb.note_request(longitude, latitude, altitude);
            if (done)
                sb.check_result(x_coord, y_coord, z_coord);
        end
    end

    task automatic send_point(logic signed [31:0] lon, logic signed [31:0] lat,
                              logic signed [31:0] alt);
        int pct;
        pct = (sent < ITEMS / 3) ? 19 : (sent < 2 * ITEMS / 3) ? 65 : 0;
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < pct)
                @(posedge clk);
        end
        start <= 1'b1;
        longitude <= lon;
        latitude <= lat;
        altitude <= alt;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    // let every request in flight come out before touching a register
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic reg_idx, logic [31:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] rand_angle();
        // mostly angles inside one turn, sometimes any bit pattern
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'(longint'($urandom_range(1509949439)) - 64'sd754974720);
    endfunction

    task automatic random_points(int n);
        for (int i = 0; i < n; i++)
            send_point(rand_angle(), rand_angle(),
                       ($urandom_range(1) == 0) ? 32'($urandom) : 32'($urandom_range(65535)));
    endtask

    initial
    begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        sb = new();
        sent = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        longitude = '0;
        latitude = '0;
        altitude = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // degree mode at reset values: quadrant edges, wraps and field extremes
        send_point(0, 0, 0);
        send_point(32'(90 * DEG), 0, 0);
        send_point(32'(180 * DEG), 32'(90 * DEG), 1000);
        send_point(32'(-180 * DEG), 32'(-90 * DEG), -1000);
        send_point(32'(270 * DEG), 32'(45 * DEG), 0);
        send_point(32'(360 * DEG), 32'(-45 * DEG), 0);
        send_point(32'(-360 * DEG), 32'(720 * DEG), 0);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_point(32'hFFFFFFFF, 1, 32'hFFFFFFFF);
        send_point(32'(45 * DEG), 32'(30 * DEG), 32'h55555555);
        send_point(32'(-135 * DEG), 32'(-60 * DEG), 32'hAAAAAAAA);
        random_points(100);

        write_reg(s2c_pkg::REG_SPHERE_RADIUS, 32'h7FFFFFFF);
        send_point(0, 0, 32'h7FFFFFFF);
        send_point(32'(180 * DEG), 32'(90 * DEG), 32'h7FFFFFFF);
        send_point(32'(45 * DEG), 32'(-90 * DEG), 32'h80000000);
        random_points(100);

        write_reg(s2c_pkg::REG_SPHERE_RADIUS, 32'hFFFFFFFF);
        random_points(40);
        write_reg(s2c_pkg::REG_SPHERE_RADIUS, 0);
        random_points(60);

        // radian mode, distance is the altitude alone
        write_reg(s2c_pkg::REG_DEGREE_MODE, 0);
        send_point(0, 0, 32'h7FFFFFFF);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h80000000);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'd210828714, 32'd421657428, 32'h12345678);   // about pi/2 and pi
        send_point(-32'd421657428, -32'd210828714, -32'h12345678);
        random_points(150);

        write_reg(s2c_pkg::REG_SPHERE_RADIUS, 32'd12345678);
        write_reg(s2c_pkg::REG_DEGREE_MODE, 32'hFFFFFFFE);
        random_points(40);
        write_reg(s2c_pkg::REG_DEGREE_MODE, 1);
        random_points(ITEMS - sent > 0 ? ITEMS - sent : 10);

        drain();
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

`default_nettype wire
